// ===== rtl/pcmd_pkg.sv =====
package pcmd_pkg;

	localparam int MAX_VECTOR_LEN = 1024;
	localparam int SAMPLE_W = 16;
	localparam int CNT_W = 11;
	localparam int SUM1_W = 26;
	localparam int SUM2_W = 42;
	localparam int PW = 106;
	localparam int MB = 53;
	localparam int RW = 137;
	localparam int QW = 32;
	localparam int ROOT_W = 16;
	localparam int REM_W = 19;
	localparam int SQRT_STEPS = 16;
	localparam int STEP_W = 6;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;

	localparam logic [2:0] OP_NSAB = 3'd0;
	localparam logic [2:0] OP_SASB = 3'd1;
	localparam logic [2:0] OP_NSAA = 3'd2;
	localparam logic [2:0] OP_SASA = 3'd3;
	localparam logic [2:0] OP_NSBB = 3'd4;
	localparam logic [2:0] OP_SBSB = 3'd5;
	localparam logic [2:0] OP_DADB = 3'd6;
	localparam logic [2:0] OP_NUM2 = 3'd7;

	typedef struct packed {
		logic       acc_en;
		logic       mul_load;
		logic       mul_step;
		logic       mul_store;
		logic       fix;
		logic       div_load;
		logic       div_step;
		logic       sqrt_load;
		logic       sqrt_step;
		logic       result_load;
		logic [2:0] op;
	} pcmd_cmd_t;

	typedef struct packed {
		logic out_full;
	} pcmd_sts_t;

endpackage

// ===== rtl/pcmd_ctrl.sv =====
module pcmd_ctrl import pcmd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	input  pcmd_sts_t sts,
	output pcmd_cmd_t cmd
);

	localparam logic [3:0] ST_ACC    = 4'd0;
	localparam logic [3:0] ST_MLOAD  = 4'd1;
	localparam logic [3:0] ST_MRUN   = 4'd2;
	localparam logic [3:0] ST_MSTORE = 4'd3;
	localparam logic [3:0] ST_FIX    = 4'd4;
	localparam logic [3:0] ST_DLOAD  = 4'd5;
	localparam logic [3:0] ST_DRUN   = 4'd6;
	localparam logic [3:0] ST_SLOAD  = 4'd7;
	localparam logic [3:0] ST_SRUN   = 4'd8;
	localparam logic [3:0] ST_OUT    = 4'd9;

	logic [3:0]        state_q;
	logic [2:0]        op_q;
	logic [STEP_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_ACC);

	always_comb begin
		cmd             = '0;
		cmd.op          = op_q;
		cmd.acc_en      = in_ready && in_valid;
		cmd.mul_load    = (state_q == ST_MLOAD);
		cmd.mul_step    = (state_q == ST_MRUN);
		cmd.mul_store   = (state_q == ST_MSTORE);
		cmd.fix         = (state_q == ST_FIX);
		cmd.div_load    = (state_q == ST_DLOAD);
		cmd.div_step    = (state_q == ST_DRUN);
		cmd.sqrt_load   = (state_q == ST_SLOAD);
		cmd.sqrt_step   = (state_q == ST_SRUN);
		cmd.result_load = (state_q == ST_OUT) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			op_q    <= OP_NSAB;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_ACC: begin
					if (in_valid && in_last) begin
						op_q    <= OP_NSAB;
						state_q <= ST_MLOAD;
					end
				end
				ST_MLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_MRUN;
				end
				ST_MRUN: begin
					if (cnt_q == STEP_W'(MB - 1)) begin
						state_q <= ST_MSTORE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MSTORE: begin
					if (op_q == OP_SBSB) begin
						state_q <= ST_FIX;
					end else if (op_q == OP_NUM2) begin
						state_q <= ST_DLOAD;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MLOAD;
					end
				end
				ST_FIX: begin
					op_q    <= OP_DADB;
					state_q <= ST_MLOAD;
				end
				ST_DLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_DRUN;
				end
				ST_DRUN: begin
					if (cnt_q == STEP_W'(QW - 1)) begin
						state_q <= ST_SLOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SLOAD: begin
					cnt_q   <= '0;
					state_q <= ST_SRUN;
				end
				ST_SRUN: begin
					if (cnt_q == STEP_W'(SQRT_STEPS - 1)) begin
						state_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!sts.out_full) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pcmd_dp.sv =====
module pcmd_dp import pcmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pcmd_cmd_t             cmd,
	input  logic [S_TDATA_W-1:0]  in_data,
	output pcmd_sts_t             sts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [M_TDATA_W-1:0]  out_data
);

	logic signed [SAMPLE_W-1:0] a, b;
	logic                       present;
	logic signed [2*SAMPLE_W-1:0] aa, bb, ab;

	logic [CNT_W-1:0]         n_q;
	logic signed [SUM1_W-1:0] sa_q, sb_q;
	logic signed [SUM2_W-1:0] saa_q, sbb_q, sab_q;

	logic signed [MB-1:0] num_q, da_q, db_q;
	logic [PW-1:0]        dd_q, x_q;
	logic                 degen_q;

	logic signed [PW-1:0] msrc;
	logic signed [MB-1:0] mop;
	logic [MB-1:0]        mmag;
	logic [PW-1:0]        acc_q, msh_q;
	logic [MB-1:0]        mm_q;
	logic                 mneg_q;
	logic [PW-1:0]        prod;

	logic signed [MB-1:0] da_c, db_c;
	logic                 degen;

	logic [RW-1:0]        r_q, dsh_q;
	logic [QW-1:0]        quo_q;

	logic [QW-1:0]        y_q;
	logic [REM_W-1:0]     rem_q, remn, trial;
	logic [ROOT_W-1:0]    root_q;
	logic [ROOT_W-1:0]    corr;

	logic                 ov_q;
	logic [M_TDATA_W-1:0] od_q;

	assign a       = in_data[15:0];
	assign b       = in_data[32:17];
	assign present = !in_data[16] && !in_data[33];
	assign aa      = a * a;
	assign bb      = b * b;
	assign ab      = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (cmd.result_load) begin
			n_q   <= '0;
			sa_q  <= '0;
			sb_q  <= '0;
			saa_q <= '0;
			sbb_q <= '0;
			sab_q <= '0;
		end else if (cmd.acc_en && present && (n_q < CNT_W'(MAX_VECTOR_LEN))) begin
			n_q   <= n_q + 1'b1;
			sa_q  <= sa_q + SUM1_W'(a);
			sb_q  <= sb_q + SUM1_W'(b);
			saa_q <= saa_q + SUM2_W'(aa);
			sbb_q <= sbb_q + SUM2_W'(bb);
			sab_q <= sab_q + SUM2_W'(ab);
		end
	end

	always_comb begin
		case (cmd.op)
			OP_NSAB: begin msrc = PW'(sab_q); mop = MB'({1'b0, n_q}); end
			OP_SASB: begin msrc = PW'(sa_q);  mop = MB'(sb_q); end
			OP_NSAA: begin msrc = PW'(saa_q); mop = MB'({1'b0, n_q}); end
			OP_SASA: begin msrc = PW'(sa_q);  mop = MB'(sa_q); end
			OP_NSBB: begin msrc = PW'(sbb_q); mop = MB'({1'b0, n_q}); end
			OP_SBSB: begin msrc = PW'(sb_q);  mop = MB'(sb_q); end
			OP_DADB: begin msrc = PW'(da_q);  mop = db_q; end
			OP_NUM2: begin msrc = PW'(num_q); mop = num_q; end
			default: begin msrc = '0;         mop = '0; end
		endcase
		mmag = mop[MB-1] ? MB'(-mop) : MB'(mop);
	end

	assign prod = mneg_q ? PW'(-acc_q) : acc_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			acc_q  <= '0;
			msh_q  <= msrc;
			mm_q   <= mmag;
			mneg_q <= mop[MB-1];
		end else if (cmd.mul_step) begin
			if (mm_q[0]) begin
				acc_q <= acc_q + msh_q;
			end
			msh_q <= {msh_q[PW-2:0], 1'b0};
			mm_q  <= {1'b0, mm_q[MB-1:1]};
		end
	end

	assign da_c  = da_q[MB-1] ? '0 : da_q;
	assign db_c  = db_q[MB-1] ? '0 : db_q;
	assign degen = (da_c == '0) || (db_c == '0);

	always_ff @(posedge clk) begin
		if (cmd.mul_store) begin
			case (cmd.op)
				OP_NSAB: num_q <= prod[MB-1:0];
				OP_SASB: num_q <= num_q - prod[MB-1:0];
				OP_NSAA: da_q  <= prod[MB-1:0];
				OP_SASA: da_q  <= da_q - prod[MB-1:0];
				OP_NSBB: db_q  <= prod[MB-1:0];
				OP_SBSB: db_q  <= db_q - prod[MB-1:0];
				OP_DADB: dd_q  <= prod;
				OP_NUM2: x_q   <= prod;
				default: ;
			endcase
		end else if (cmd.fix) begin
			da_q    <= degen ? MB'(1) : da_c;
			db_q    <= degen ? MB'(1) : db_c;
			degen_q <= degen;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			r_q   <= RW'({x_q, 30'b0});
			dsh_q <= RW'({dd_q, 31'b0});
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (r_q >= dsh_q) begin
				r_q   <= r_q - dsh_q;
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
			dsh_q <= {1'b0, dsh_q[RW-1:1]};
		end
	end

	assign remn  = {rem_q[REM_W-3:0], y_q[QW-1:QW-2]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_load) begin
			y_q    <= quo_q;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			y_q <= {y_q[QW-3:0], 2'b00};
			if (remn >= trial) begin
				rem_q  <= remn - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= remn;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (num_q[MB-1]) begin
			corr = root_q[ROOT_W-1] ? 16'h8000 : ROOT_W'(-root_q);
		end else begin
			corr = root_q[ROOT_W-1] ? 16'h7fff : root_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.result_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			od_q <= {4'b0, degen_q, n_q, corr};
		end
	end

	assign out_valid    = ov_q;
	assign out_data     = od_q;
	assign sts.out_full = ov_q && !out_ready;

endmodule

// ===== rtl/pearson_correlation_missing_data_unit.sv =====
// Pairwise-complete Pearson correlation of two rows.
// Input channel s_axis: one beat per element pair; tlast marks the final pair.
//   Pairs with either missing flag set are skipped; at most 1024 pairs count.
// Output channel m_axis: one beat per row pair, issued after the tlast beat:
//   correlation (Q1.15, saturated to +-1), valid_pairs, degenerate.
// Throughput: one element pair per cycle while the row streams in.
// After the tlast beat the result is computed by the shared bit-serial
//   multiplier (8 products), a 32-step restoring divider and a 16-step
//   square root. s_axis_tready stays low from the tlast beat until the
//   result is loaded into the output register.
// The result sits in an output register; a stalled receiver does not block
//   the next row, which may stream in while the result waits. A new result
//   waits in the controller until the register is free.
// Reset clears the sums, the pair count, the controller and the output valid.
module pearson_correlation_missing_data_unit import pcmd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// a_value[15:0], a_missing[16], b_value[32:17], b_missing[33], zero[39:34]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// correlation[15:0], valid_pairs[26:16], degenerate[27], zero[31:28]
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	pcmd_cmd_t cmd;
	pcmd_sts_t sts;

	pcmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pcmd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input accepted while computing");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[27] |-> m_axis_tdata[15:0] == 16'h0000)
		else $error("degenerate result with nonzero correlation");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[26:16] <= 11'd1024)
		else $error("pair count out of range");
`endif

endmodule
